### design/mce_pkg.sv
// package for the morse character encoder
// holds element codes, command codes, the queue entry type and the symbol table
// no dependencies
`default_nettype none

package mce_pkg;

  // element codes on the result channel
  localparam logic [1:0] KIND_DOT  = 2'd0;
  localparam logic [1:0] KIND_DASH = 2'd1;
  localparam logic [1:0] KIND_GAP  = 2'd2;
  localparam logic [1:0] KIND_RSV  = 2'd3;

  // command characters
  localparam logic [7:0] CHAR_SPACE_OFF = 8'h3C;  // '<'
  localparam logic [7:0] CHAR_SPACE_ON  = 8'h3E;  // '>'

  // trailing gap counts
  localparam logic [2:0] GAPS_NONE = 3'd0;
  localparam logic [2:0] GAPS_PAIR = 3'd2;

  // symbol: left-aligned pattern, first element at bit 5, 1 = dash
  typedef struct packed {
    logic [2:0] len;
    logic [5:0] pattern;
  } mce_sym_t;

  // one queue entry: what the back end has to key for a character
  typedef struct packed {
    logic [5:0] pattern;
    logic [2:0] sym_len;
    logic [2:0] tail_gaps;
  } mce_cmd_t;

  // back end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } mce_bk_state_t;

  // international morse table, len 0 means no symbol
  function automatic mce_sym_t sym_lookup(input logic [7:0] c);
    mce_sym_t s;
    s = '{len: 3'd0, pattern: 6'b000000};
    case (c)
      "0":      s = '{3'd5, 6'b111110};
      "1":      s = '{3'd5, 6'b011110};
      "2":      s = '{3'd5, 6'b001110};
      "3":      s = '{3'd5, 6'b000110};
      "4":      s = '{3'd5, 6'b000010};
      "5":      s = '{3'd5, 6'b000000};
      "6":      s = '{3'd5, 6'b100000};
      "7":      s = '{3'd5, 6'b110000};
      "8":      s = '{3'd5, 6'b111000};
      "9":      s = '{3'd5, 6'b111100};
      "A", "a": s = '{3'd2, 6'b010000};
      "B", "b": s = '{3'd4, 6'b100000};
      "C", "c": s = '{3'd4, 6'b101000};
      "D", "d": s = '{3'd3, 6'b100000};
      "E", "e": s = '{3'd1, 6'b000000};
      "F", "f": s = '{3'd4, 6'b001000};
      "G", "g": s = '{3'd3, 6'b110000};
      "H", "h": s = '{3'd4, 6'b000000};
      "I", "i": s = '{3'd2, 6'b000000};
      "J", "j": s = '{3'd4, 6'b011100};
      "K", "k": s = '{3'd3, 6'b101000};
      "L", "l": s = '{3'd4, 6'b010000};
      "M", "m": s = '{3'd2, 6'b110000};
      "N", "n": s = '{3'd2, 6'b100000};
      "O", "o": s = '{3'd3, 6'b111000};
      "P", "p": s = '{3'd4, 6'b011000};
      "Q", "q": s = '{3'd4, 6'b110100};
      "R", "r": s = '{3'd3, 6'b010000};
      "S", "s": s = '{3'd3, 6'b000000};
      "T", "t": s = '{3'd1, 6'b100000};
      "U", "u": s = '{3'd3, 6'b001000};
      "V", "v": s = '{3'd4, 6'b000100};
      "W", "w": s = '{3'd3, 6'b011000};
      "X", "x": s = '{3'd4, 6'b100100};
      "Y", "y": s = '{3'd4, 6'b101100};
      "Z", "z": s = '{3'd4, 6'b110000};
      8'h22:    s = '{3'd6, 6'b010010};  // double quote
      "&":      s = '{3'd5, 6'b010000};
      8'h27:    s = '{3'd6, 6'b011110};  // apostrophe
      "(":      s = '{3'd5, 6'b101100};
      ")":      s = '{3'd6, 6'b101101};
      "+":      s = '{3'd5, 6'b010100};
      ",":      s = '{3'd6, 6'b110011};
      "-":      s = '{3'd6, 6'b100001};
      ".":      s = '{3'd6, 6'b010101};
      "/":      s = '{3'd5, 6'b100100};
      ":":      s = '{3'd6, 6'b111000};
      "=":      s = '{3'd5, 6'b100010};
      "?":      s = '{3'd6, 6'b001100};
      "@":      s = '{3'd6, 6'b011010};
      default:  s = '{3'd0, 6'b000000};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### design/mce_char_if.sv
// character channel: valid/ready handshake with an 8-bit character code
// no dependencies
`default_nettype none

interface mce_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

### design/mce_elem_if.sv
// keying element channel: valid/ready handshake with element kind and last flag
// no dependencies
`default_nettype none

interface mce_elem_if;
  logic       valid;
  logic       ready;
  logic [1:0] element_kind;
  logic       last_element;

  modport source (output valid, output element_kind, output last_element, input ready);
  modport sink   (input valid, input element_kind, input last_element, output ready);
endinterface

`default_nettype wire

### design/morse_character_encoder.sv
// Morse character encoder: one character in, a run of dot, dash and gap elements out.
// A character is accepted while the two-entry command queue has room.
// The back-end sequencer then keys one element per cycle when the output is
// taken: two per symbol element plus trailing gaps, up to 14, and spends a
// load step on each queued character before keying its elements. The '<'
// character keys nothing and takes no back-end time.
// Depends on mce_pkg, mce_char_if, mce_elem_if, mce_front, mce_cmd_fifo, mce_back.
`default_nettype none

module morse_character_encoder (
  input  wire logic  clk,
  input  wire logic  rst,
  mce_char_if.sink   char_in,
  mce_elem_if.source elem_out
);

  mce_pkg::mce_cmd_t push_cmd;
  logic              push_valid;
  logic              push_ready;
  mce_pkg::mce_cmd_t pop_cmd;
  logic              pop_valid;
  logic              pop_ready;

  // classify and track spacing
  mce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .cmd       (push_cmd),
    .cmd_valid (push_valid),
    .cmd_ready (push_ready)
  );

  // decoupling queue
  mce_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // element sequencer
  mce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (pop_cmd),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .elem_out  (elem_out)
  );

  // the reserved element code is never keyed
  a_no_rsv_kind: assert property (@(posedge clk) disable iff (rst)
    elem_out.valid |-> elem_out.element_kind != mce_pkg::KIND_RSV)
    else $error("reserved element kind on output");

  // spacing-off command never reaches the queue
  a_off_no_push: assert property (@(posedge clk) disable iff (rst)
    (char_in.valid && char_in.ready && char_in.char_code == mce_pkg::CHAR_SPACE_OFF)
      |-> !push_valid)
    else $error("spacing-off command queued");

  // every queued command keys at least one element
  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (push_cmd.sym_len != 3'd0 || push_cmd.tail_gaps != 3'd0))
    else $error("empty command queued");

endmodule

`default_nettype wire

### design/mce_front.sv
// front end: accepts characters, looks up the symbol, tracks letter spacing
// depends on mce_pkg and mce_char_if
`default_nettype none

module mce_front (
  input  wire logic          clk,
  input  wire logic          rst,
  mce_char_if.sink           char_in,
  output mce_pkg::mce_cmd_t  cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready
);

  logic              spacing_on;
  logic              spacing_on_next;
  mce_pkg::mce_sym_t sym;
  logic              is_off;
  logic              is_on;
  logic [2:0]        word_gaps;
  logic [2:0]        tail_gaps;

  // classify the character
  always_comb begin
    sym    = mce_pkg::sym_lookup(char_in.char_code);
    is_off = (char_in.char_code == mce_pkg::CHAR_SPACE_OFF);
    is_on  = (char_in.char_code == mce_pkg::CHAR_SPACE_ON);

    spacing_on_next = spacing_on;
    if (is_off) begin
      spacing_on_next = 1'b0;
    end else if (is_on) begin
      spacing_on_next = 1'b1;
    end

    // word space for codes with no symbol that are not spacing commands
    word_gaps = (sym.len == 3'd0 && !is_off && !is_on) ? mce_pkg::GAPS_PAIR
                                                       : mce_pkg::GAPS_NONE;
    tail_gaps = word_gaps + (spacing_on_next ? mce_pkg::GAPS_PAIR : mce_pkg::GAPS_NONE);

    cmd.pattern   = sym.pattern;
    cmd.sym_len   = sym.len;
    cmd.tail_gaps = tail_gaps;
  end

  // only characters that key something go into the queue
  assign cmd_valid     = char_in.valid && (sym.len != 3'd0 || tail_gaps != 3'd0);
  assign char_in.ready = cmd_ready;

  // spacing flag
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing_on <= 1'b1;
    end else if (char_in.valid && char_in.ready) begin
      spacing_on <= spacing_on_next;
    end
  end

endmodule

`default_nettype wire

### design/mce_cmd_fifo.sv
// two-entry command queue between front and back end
// depends on mce_pkg
`default_nettype none

module mce_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mce_pkg::mce_cmd_t push_cmd,
  input  wire logic          push_valid,
  output logic               push_ready,
  output mce_pkg::mce_cmd_t  pop_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready
);

  mce_pkg::mce_cmd_t mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### design/mce_back.sv
// back end: steps through one command and keys its elements, one per cycle while the output is taken
// depends on mce_pkg and mce_elem_if
`default_nettype none

module mce_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mce_pkg::mce_cmd_t cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  mce_elem_if.source         elem_out
);

  mce_pkg::mce_bk_state_t state;
  mce_pkg::mce_bk_state_t state_next;
  logic [5:0] pattern;
  logic [5:0] pattern_next;
  logic [3:0] step;
  logic [3:0] step_next;
  logic [3:0] len2;
  logic [3:0] len2_next;
  logic [3:0] total;
  logic [3:0] total_next;
  logic       out_valid;
  logic       out_valid_next;
  logic [1:0] out_kind;
  logic [1:0] out_kind_next;
  logic       out_last;
  logic       out_last_next;
  logic       advance;
  logic       in_symbol;
  logic       is_final;

  assign advance   = !out_valid || elem_out.ready;
  assign in_symbol = (step < len2);
  assign is_final  = (step == total - 4'd1);
  assign cmd_ready = (state == mce_pkg::BK_IDLE);

  // sequencer next state and element selection
  always_comb begin
    state_next     = state;
    pattern_next   = pattern;
    step_next      = step;
    len2_next      = len2;
    total_next     = total;
    out_valid_next = out_valid;
    out_kind_next  = out_kind;
    out_last_next  = out_last;

    if (out_valid && elem_out.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      mce_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          pattern_next = cmd.pattern;
          step_next    = 4'd0;
          len2_next    = {cmd.sym_len, 1'b0};
          total_next   = {cmd.sym_len, 1'b0} + {1'b0, cmd.tail_gaps};
          state_next   = mce_pkg::BK_RUN;
        end
      end
      mce_pkg::BK_RUN: begin
        if (advance) begin
          out_valid_next = 1'b1;
          out_last_next  = is_final;
          if (in_symbol && !step[0]) begin
            // tone from the top of the pattern, then shift it out
            out_kind_next = pattern[5] ? mce_pkg::KIND_DASH : mce_pkg::KIND_DOT;
            pattern_next  = {pattern[4:0], 1'b0};
          end else begin
            out_kind_next = mce_pkg::KIND_GAP;
          end
          step_next = step + 4'd1;
          if (is_final) begin
            state_next = mce_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_next = mce_pkg::BK_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mce_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk) begin
    pattern  <= pattern_next;
    step     <= step_next;
    len2     <= len2_next;
    total    <= total_next;
    out_kind <= out_kind_next;
    out_last <= out_last_next;
  end

  assign elem_out.valid        = out_valid;
  assign elem_out.element_kind = out_kind;
  assign elem_out.last_element = out_last;

endmodule

`default_nettype wire

### verif/mce_key_checker.sv
// element checker for the morse character encoder: watches both channels,
// predicts the keying run of every accepted character and compares results
// depends on mce_pkg, mce_char_if and mce_elem_if
`default_nettype none

module mce_key_checker (
  input  wire logic clk,
  input  wire logic rst,
  mce_char_if       ch,
  mce_elem_if       el,
  output int        fail_cnt,
  output int        pending_cnt
);

  timeunit 1ns;
  timeprecision 1ps;

  // one predicted keying element
  typedef struct packed {
    logic [1:0] kind;
    logic       last;
  } key_elem_t;

  key_elem_t key_q[$];
  logic      spacing_on;
  int        errors;

  // dot/dash pattern per character, empty string when no symbol exists
  function automatic string morse_pattern(input logic [7:0] c);
    case (c)
      "0":      return "-----";
      "1":      return ".----";
      "2":      return "..---";
      "3":      return "...--";
      "4":      return "....-";
      "5":      return ".....";
      "6":      return "-....";
      "7":      return "--...";
      "8":      return "---..";
      "9":      return "----.";
      "A", "a": return ".-";
      "B", "b": return "-...";
      "C", "c": return "-.-.";
      "D", "d": return "-..";
      "E", "e": return ".";
      "F", "f": return "..-.";
      "G", "g": return "--.";
      "H", "h": return "....";
      "I", "i": return "..";
      "J", "j": return ".---";
      "K", "k": return "-.-";
      "L", "l": return ".-..";
      "M", "m": return "--";
      "N", "n": return "-.";
      "O", "o": return "---";
      "P", "p": return ".--.";
      "Q", "q": return "--.-";
      "R", "r": return ".-.";
      "S", "s": return "...";
      "T", "t": return "-";
      "U", "u": return "..-";
      "V", "v": return "...-";
      "W", "w": return ".--";
      "X", "x": return "-..-";
      "Y", "y": return "-.--";
      "Z", "z": return "--..";
      8'h22:    return ".-..-.";
      "&":      return ".-...";
      8'h27:    return ".----.";
      "(":      return "-.--.";
      ")":      return "-.--.-";
      "+":      return ".-.-.";
      ",":      return "--..--";
      "-":      return "-....-";
      ".":      return ".-.-.-";
      "/":      return "-..-.";
      ":":      return "---...";
      "=":      return "-...-";
      "?":      return "..--..";
      "@":      return ".--.-.";
      default:  return "";
    endcase
  endfunction

  function automatic key_elem_t mk_elem(input logic [1:0] kind);
    key_elem_t e;
    e.kind = kind;
    e.last = 1'b0;
    return e;
  endfunction

  // predict on accepted characters, compare on accepted elements
  always @(posedge clk) begin
    string     pat;
    int        n_before;
    logic [7:0] c;
    key_elem_t got;
    key_elem_t want;
    if (rst) begin
      key_q.delete();
      spacing_on = 1'b1;
      errors = 0;
    end else begin
      if (ch.valid && ch.ready) begin
        c = ch.char_code;
        pat = morse_pattern(c);
        n_before = key_q.size();
        if (pat.len() > 0) begin
          for (int i = 0; i < pat.len(); i++) begin
            key_q.push_back(mk_elem(pat[i] == "-" ? mce_pkg::KIND_DASH : mce_pkg::KIND_DOT));
            key_q.push_back(mk_elem(mce_pkg::KIND_GAP));
          end
        end else if (c == mce_pkg::CHAR_SPACE_OFF) begin
          spacing_on = 1'b0;
        end else if (c == mce_pkg::CHAR_SPACE_ON) begin
          spacing_on = 1'b1;
        end else begin
          // word space for anything without a symbol
          key_q.push_back(mk_elem(mce_pkg::KIND_GAP));
          key_q.push_back(mk_elem(mce_pkg::KIND_GAP));
        end
        // inter-letter spacing
        if (spacing_on) begin
          key_q.push_back(mk_elem(mce_pkg::KIND_GAP));
          key_q.push_back(mk_elem(mce_pkg::KIND_GAP));
        end
        if (key_q.size() > n_before) begin
          key_q[key_q.size() - 1].last = 1'b1;
        end
      end
      if (el.valid && el.ready) begin
        got.kind = el.element_kind;
        got.last = el.last_element;
        if (key_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected element: expected none, got kind %0d last %0d",
                   $time, got.kind, got.last);
        end else begin
          want = key_q.pop_front();
          if (got.kind !== want.kind || got.last !== want.last) begin
            errors++;
            $display("%0t: element mismatch: expected kind %0d last %0d, got kind %0d last %0d",
                     $time, want.kind, want.last, got.kind, got.last);
          end
        end
      end
    end
    fail_cnt    <= errors;
    pending_cnt <= key_q.size();
  end

endmodule

`default_nettype wire

### verif/tb_morse_character_encoder.sv
// testbench top for the morse character encoder: clock, reset, character
// stimulus under several idling phases, receiver stalls and the verdict
// depends on mce_pkg, both channel interfaces, the block and mce_key_checker
`default_nettype none

module tb_morse_character_encoder;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASE_ITEMS = 16;

  // idling phases
  typedef enum int {
    MODE_NONE,
    MODE_TX_IDLE,
    MODE_RX_STALL,
    MODE_BOTH
  } idle_mode_t;

  logic       clk;
  logic       rst;
  idle_mode_t idle_mode;
  int         hold_seq;
  int         hold_seen;
  int         hold_cnt;
  int         cycle_cnt;
  int         fail_cnt;
  int         pending_cnt;

  mce_char_if char_bus ();
  mce_elem_if elem_bus ();

  morse_character_encoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_bus),
    .elem_out (elem_bus)
  );

  mce_key_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .ch          (char_bus),
    .el          (elem_bus),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int tx_idle_pct(input idle_mode_t m);
    case (m)
      MODE_TX_IDLE: return 56;
      MODE_BOTH:    return 8;
      default:      return 0;
    endcase
  endfunction

  function automatic int rx_stall_pct(input idle_mode_t m);
    case (m)
      MODE_RX_STALL: return 56;
      MODE_BOTH:     return 8;
      default:       return 0;
    endcase
  endfunction

  // receiver: random stalls plus a long hold-off on request
  initial elem_bus.ready = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      hold_seen = 0;
      hold_cnt = 0;
      elem_bus.ready <= 1'b0;
    end else begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        elem_bus.ready <= 1'b0;
      end else begin
        elem_bus.ready <= !roll(rx_stall_pct(idle_mode));
      end
    end
  end

  // watchdog
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_morse_character_encoder: errors");
      $finish;
    end
  end

  // offer one character and wait for its transaction
  task automatic send_char(input logic [7:0] c);
    while (roll(tx_idle_pct(idle_mode))) begin
      char_bus.valid <= 1'b0;
      @(posedge clk);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
  endtask

  // stop offering until every predicted element has come out
  task automatic wait_drained();
    char_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  task automatic enter_phase(input idle_mode_t m);
    wait_drained();
    idle_mode <= m;
    @(posedge clk);
  endtask

  // mostly table characters, some spacing commands and raw bytes
  function automatic logic [7:0] pick_char();
    string legal;
    int    r;
    legal = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz\"&'()+,-./:=?@";
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return legal[$urandom_range(0, legal.len() - 1)];
    end else if (r < 85) begin
      return $urandom_range(0, 1) ? mce_pkg::CHAR_SPACE_OFF : mce_pkg::CHAR_SPACE_ON;
    end else begin
      return 8'($urandom_range(0, 255));
    end
  endfunction

  // stimulus and verdict
  initial begin
    rst = 1'b1;
    idle_mode = MODE_NONE;
    hold_seq = 0;
    char_bus.valid = 1'b0;
    char_bus.char_code = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, longest runs, spacing commands, word spaces
    send_char(8'h00);
    send_char("0");
    send_char("5");
    send_char("9");
    send_char("A");
    send_char("z");
    send_char("E");
    send_char("T");
    send_char(")");
    send_char(8'h22);
    send_char(8'h27);
    send_char("@");
    send_char(mce_pkg::CHAR_SPACE_OFF);
    send_char("A");
    send_char("x" + 8'd8);
    send_char(mce_pkg::CHAR_SPACE_OFF);
    send_char(8'h00);
    send_char(")");
    send_char(mce_pkg::CHAR_SPACE_ON);
    send_char(mce_pkg::CHAR_SPACE_ON);
    send_char(8'hFF);
    send_char(8'h80);
    send_char("?");
    send_char(",");
    send_char(8'h7F);

    // random items under each idling phase
    enter_phase(MODE_NONE);
    repeat (PHASE_ITEMS) send_char(pick_char());
    enter_phase(MODE_TX_IDLE);
    repeat (PHASE_ITEMS) send_char(pick_char());
    enter_phase(MODE_RX_STALL);
    repeat (PHASE_ITEMS) send_char(pick_char());
    enter_phase(MODE_BOTH);
    repeat (PHASE_ITEMS) send_char(pick_char());

    // long receiver hold-off so the queue fills and input stalls
    enter_phase(MODE_NONE);
    hold_seq <= hold_seq + 1;
    send_char(mce_pkg::CHAR_SPACE_ON);
    repeat (9) send_char("0");

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_morse_character_encoder: clean");
    end else begin
      $display("tb_morse_character_encoder: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
